// ----- rtl/apa_pkg.sv -----
// ----------------------------------------------------------------------------
// apa_pkg: shared types and constants of the address pool allocator
// constants for the bitmap cell row, the request kinds and the cell control
// ----------------------------------------------------------------------------
package apa_pkg;

    localparam int POOL_SIZE  = 255;
    localparam int ADDR_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int CELL_W     = 16;
    localparam int NUM_CELLS  = 16;
    localparam int BIT_IDX_W  = $clog2(CELL_W);
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int POP_W      = $clog2(CELL_W + 1);

    typedef enum logic [2:0] {
        KIND_PEEK    = 3'd0,
        KIND_ACQUIRE = 3'd1,
        KIND_LEASE   = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_INIT    = 3'd4
    } apa_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } apa_state_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic                  shift;
        logic                  fill;
        logic                  wr_en;
        logic                  wr_val;
        logic [CELL_IDX_W-1:0] wr_cell;
        logic [BIT_IDX_W-1:0]  wr_bit;
    } apa_cell_ctrl_t;

    // free bits of one cell after initialize; padding bits above the pool stay taken
    function automatic logic [CELL_W-1:0] fill_word(input int cell_id);
        logic [CELL_W-1:0] w;
        w = '0;
        for (int b = 0; b < CELL_W; b++) begin
            w[b] = ((cell_id * CELL_W + b) < POOL_SIZE);
        end
        return w;
    endfunction

    function automatic logic [POP_W-1:0] pop_count(input logic [CELL_W-1:0] w);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < CELL_W; b++) begin
            n = n + POP_W'(w[b]);
        end
        return n;
    endfunction

endpackage

// ----- rtl/apa_cell.sv -----
// ----------------------------------------------------------------------------
// apa_cell: one cell of the free bitmap ring
// holds one word of free bits, loads its start word on initialize, its
// neighbor's word on a shift step and takes single-bit updates when selected
// ----------------------------------------------------------------------------
module apa_cell
    import apa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  apa_cell_ctrl_t       ctrl,
    input  logic                 sel,
    input  logic [CELL_W-1:0]    init_word,
    input  logic [CELL_W-1:0]    nb_word,
    output logic [CELL_W-1:0]    word
);

    logic [CELL_W-1:0] word_reg;
    logic [CELL_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        priority if (ctrl.fill) begin
            word_next = init_word;
        end else if (ctrl.shift) begin
            word_next = nb_word;
        end else if (ctrl.wr_en && sel) begin
            word_next[ctrl.wr_bit] = ctrl.wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= init_word;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

// ----- rtl/apa_ctrl.sv -----
// ----------------------------------------------------------------------------
// apa_ctrl: request sequencer of the address pool allocator
// runs the free count, drives the cell row and searches the head cell for the
// n-th free address while the ring turns once
// ----------------------------------------------------------------------------
module apa_ctrl
    import apa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_kind,
    input  logic [ADDR_W-1:0]    s_index,
    input  logic [ADDR_W-1:0]    s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_found_address,
    output logic                 m_status,
    output logic [COUNT_W-1:0]   m_free_count,
    output logic                 m_pool_empty,
    input  logic [CELL_W-1:0]    head_word,
    input  logic                 map_bit,
    output apa_cell_ctrl_t       cell_ctrl,
    output logic [CELL_W-1:0]    clr_mask
);

    localparam logic [COUNT_W-1:0] POOL_COUNT = COUNT_W'(POOL_SIZE);
    localparam logic [CELL_IDX_W-1:0] LAST_STEP = CELL_IDX_W'(NUM_CELLS - 1);

    apa_state_t               state_reg, state_next;
    logic [CELL_IDX_W-1:0]    step_reg, step_next;
    logic [ADDR_W-1:0]        remain_reg, remain_next;
    logic                     hit_reg, hit_next;
    logic                     acq_reg, acq_next;
    logic [ADDR_W-1:0]        found_reg, found_next;
    logic                     status_reg, status_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    logic                     m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]        m_found_reg;
    logic                     m_status_reg;
    logic [COUNT_W-1:0]       m_count_reg;
    logic                     m_empty_reg;

    apa_kind_t                kind;
    logic                     accept;
    logic                     load;
    logic                     is_find;
    logic                     in_range;
    logic                     addr_ok;
    logic [POP_W-1:0]         head_pop;
    logic                     head_hit;
    logic [CELL_W-1:0]        sel_oh;
    logic [BIT_IDX_W-1:0]     sel_bit;

    assign kind     = apa_kind_t'(s_kind);
    assign accept   = s_valid && s_ready;
    assign is_find  = (kind == KIND_PEEK) || (kind == KIND_ACQUIRE);
    assign in_range = s_index < count_reg;
    assign addr_ok  = s_address < ADDR_W'(POOL_SIZE);
    assign load     = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    // search inside the word now at the head of the ring
    assign head_pop = pop_count(head_word);
    assign head_hit = remain_reg < ADDR_W'(head_pop);

    always_comb begin
        sel_oh  = '0;
        sel_bit = '0;
        for (int j = 0; j < CELL_W; j++) begin
            sel_oh[j] = head_word[j]
                && (ADDR_W'(pop_count(head_word & ((CELL_W'(1) << j) - CELL_W'(1))))
                    == remain_reg);
        end
        for (int j = 0; j < CELL_W; j++) begin
            if (sel_oh[j]) begin
                sel_bit = sel_bit | BIT_IDX_W'(j);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (is_find && in_range) ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN: begin
                if (step_reg == LAST_STEP) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs toward the input channel and the cell row
    always_comb begin
        s_ready   = 1'b0;
        cell_ctrl = '0;
        clr_mask  = '0;
        cell_ctrl.wr_cell = s_address[BIT_IDX_W +: CELL_IDX_W];
        cell_ctrl.wr_bit  = s_address[BIT_IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    unique case (kind)
                        KIND_LEASE: begin
                            cell_ctrl.wr_en  = addr_ok && map_bit;
                            cell_ctrl.wr_val = 1'b0;
                        end
                        KIND_RELEASE: begin
                            cell_ctrl.wr_en  = addr_ok && !map_bit;
                            cell_ctrl.wr_val = 1'b1;
                        end
                        KIND_INIT: begin
                            cell_ctrl.fill = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cell_ctrl.shift = 1'b1;
                if (acq_reg && !hit_reg && head_hit) begin
                    clr_mask = sel_oh;
                end
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // request datapath
    always_comb begin
        step_next   = step_reg;
        remain_next = remain_reg;
        hit_next    = hit_reg;
        acq_next    = acq_reg;
        found_next  = found_reg;
        status_next = status_reg;
        count_next  = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    step_next   = '0;
                    remain_next = s_index;
                    hit_next    = 1'b0;
                    acq_next    = (kind == KIND_ACQUIRE);
                    found_next  = '0;
                    status_next = is_find && !in_range;
                    unique case (kind)
                        KIND_LEASE: begin
                            if (addr_ok && map_bit) begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        KIND_RELEASE: begin
                            if (addr_ok && !map_bit) begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        KIND_INIT: begin
                            count_next = POOL_COUNT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                step_next = (step_reg == LAST_STEP) ? '0 : step_reg + CELL_IDX_W'(1);
                if (!hit_reg) begin
                    if (head_hit) begin
                        hit_next   = 1'b1;
                        found_next = {step_reg, sel_bit};
                        if (acq_reg) begin
                            count_next = count_reg - COUNT_W'(1);
                        end
                    end else begin
                        remain_next = remain_reg - ADDR_W'(head_pop);
                    end
                end
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            count_reg   <= POOL_COUNT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            hit_reg     <= hit_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        remain_reg <= remain_next;
        acq_reg    <= acq_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (load) begin
            m_found_reg  <= found_reg;
            m_status_reg <= status_reg;
            m_count_reg  <= count_reg;
            m_empty_reg  <= (count_reg == '0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found_address = m_found_reg;
    assign m_status        = m_status_reg;
    assign m_free_count    = m_count_reg;
    assign m_pool_empty    = m_empty_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POOL_COUNT)
        else $error("free count above pool size");

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_SCAN |-> step_reg == '0)
        else $error("cell ring not at home position outside a scan");

    a_scan_finds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && step_reg == LAST_STEP) |=> hit_reg)
        else $error("in-range search ended without a free address");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_empty_reg == (m_count_reg == '0)))
        else $error("empty flag disagrees with free count");
`endif

endmodule

// ----- rtl/address_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// address_pool_allocator_top: bitmap free list of addresses 0 to 254
// peek, acquire, lease, release and initialize over a ring of bitmap cells
// ----------------------------------------------------------------------------
// peek and acquire with an index below the free count: the ring of 16 cells
//   turns once in scan steps, then the result waits in the hold state
// all other requests: the result waits in the hold state straight away
// the result enters the output register when that register is empty or m_ready
//   is high; a new request is taken in the cycle after that, so one at a time
// reset (aresetn low, synchronous): every address free, free count 255
// ----------------------------------------------------------------------------
module address_pool_allocator_top
    import apa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_kind,
    input  logic [ADDR_W-1:0]    s_index,
    input  logic [ADDR_W-1:0]    s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_found_address,
    output logic                 m_status,
    output logic [COUNT_W-1:0]   m_free_count,
    output logic                 m_pool_empty
);

    // cell i holds addresses i*16 .. i*16+15 while the ring is at home;
    // during a search the words move one cell toward cell 0 each cycle,
    // so cell 0 shows word k in scan step k and the ring is home again
    // after 16 steps
    logic [CELL_W-1:0]  cell_word [NUM_CELLS];
    apa_cell_ctrl_t     cell_ctrl;
    logic [CELL_W-1:0]  clr_mask;
    logic [CELL_W-1:0]  wrap_word;
    logic               map_bit;

    // an acquired address drops out of the head word as it wraps around
    assign wrap_word = cell_word[0] & ~clr_mask;

    // current free bit of the request address, used by lease and release
    assign map_bit = cell_word[s_address[BIT_IDX_W +: CELL_IDX_W]][s_address[BIT_IDX_W-1:0]];

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic [CELL_W-1:0] nb_word;

        if (i == NUM_CELLS - 1) begin : g_wrap
            assign nb_word = wrap_word;
        end else begin : g_link
            assign nb_word = cell_word[i + 1];
        end

        apa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .sel       (cell_ctrl.wr_cell == CELL_IDX_W'(i)),
            .init_word (fill_word(i)),
            .nb_word   (nb_word),
            .word      (cell_word[i])
        );
    end

    // sequencer: free count, search through the head cell, output register
    apa_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_index         (s_index),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found_address (m_found_address),
        .m_status        (m_status),
        .m_free_count    (m_free_count),
        .m_pool_empty    (m_pool_empty),
        .head_word       (cell_word[0]),
        .map_bit         (map_bit),
        .cell_ctrl       (cell_ctrl),
        .clr_mask        (clr_mask)
    );

endmodule
